/* hw/rtl/scm_pkg.sv */
// ----------------------------------------------------------------------------
// scm_pkg
// Shared widths, types and helpers for the scan-line confidence map.
// ----------------------------------------------------------------------------
package scm_pkg;

    // Field and configuration widths
    localparam int PIX_W    = 8;
    localparam int CFG_W    = 9;
    localparam int OUT_W    = 8;
    // Wide enough to compare any index against any configured count
    localparam int CNT_W    = 13;
    // Squared pixel offset, column energy and arithmetic unit widths
    localparam int SQ_W     = 16;
    localparam int ENERGY_W = 25;
    localparam int ALU_W    = ENERGY_W + 1;
    localparam int NUM_W    = ENERGY_W + OUT_W;

    // Configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    localparam logic [OUT_W-1:0] CONF_FULL = 8'hFF;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } t_alu_rsp;

endpackage

/* hw/rtl/scm_alu.sv */
// ----------------------------------------------------------------------------
// scm_alu
// Shared add / compare-subtract unit: column sums, energy removal and the
// restoring division steps all run through it.
// ----------------------------------------------------------------------------
module scm_alu (
    input  scm_pkg::t_alu_req i_req,
    output scm_pkg::t_alu_rsp o_rsp
);
    import scm_pkg::*;

    logic [ALU_W:0] w_sum;

    // Borrow out of the top bit means a < b on a subtract
    always_comb begin
        if (i_req.op == ALU_SUB) begin
            w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
        o_rsp.res    = w_sum[ALU_W-1:0];
        o_rsp.borrow = (i_req.op == ALU_SUB) ? w_sum[ALU_W] : 1'b0;
    end

endmodule

/* hw/rtl/scm_store.sv */
// ----------------------------------------------------------------------------
// scm_store
// Image memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scm_store #(
    parameter int AW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [scm_pkg::PIX_W-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic [scm_pkg::PIX_W-1:0] o_rdata
);
    import scm_pkg::*;

    logic [PIX_W-1:0] r_mem [2**AW];
    logic [PIX_W-1:0] r_rdata;

    // Write a loaded pixel
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, enabled by i_re
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/scanline_confidence_map.sv */
// ----------------------------------------------------------------------------
// scanline_confidence_map
// Loads an 8-bit image row-major and returns per-pixel confidence values in
// column order, from the remaining squared-offset energy of each column.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. i_kind selects a
//   load (i_pixel is written at the next row-major position) or a fetch.
//   Loads never raise busy. A load after a completed
//   image starts a new one.
//   A fetch on a completed image returns one value on o_out_* with o_valid
//   high for exactly one cycle; fetches before the image is complete or
//   after the value marked o_last return nothing.
//   Row 0 of a column walks the column once through the image memory;
//   its result comes in the first cycle with busy low.
//   Other rows read one pixel, square it, remove its energy and, if the
//   column energy is nonzero, run an 8-step restoring division on the
//   shared subtract unit.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) are taken at once
//   and abandon the current image; write only while busy is low.
//   Reset (synchronous, active low) returns to the empty-image state with
//   256 x 256 in use; memory contents are not cleared. The receiver cannot
//   stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module scanline_confidence_map #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_kind,
    input  logic [scm_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [scm_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_valid,
    output logic [scm_pkg::OUT_W-1:0] o_out_row,
    output logic [scm_pkg::OUT_W-1:0] o_out_col,
    output logic [scm_pkg::OUT_W-1:0] o_confidence,
    output logic                      o_last
);
    import scm_pkg::*;

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = RW + CW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_SQ,
        S_SUB,
        S_NUM,
        S_DIV
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_cfg_rows;
    logic [CFG_W-1:0]     r_cfg_cols;
    logic [PIX_W-1:0]     r_min;
    logic                 r_full;
    logic                 r_ready;
    logic [RW-1:0]        r_ld_row;
    logic [CW-1:0]        r_ld_col;
    logic [RW-1:0]        r_emit_row;
    logic [CW-1:0]        r_emit_col;
    logic [RW-1:0]        r_walk_row;
    logic                 r_walk_busy;
    logic                 r_v1;
    logic                 r_v2;
    logic [SQ_W-1:0]      r_sq;
    logic [ENERGY_W-1:0]  r_total;
    logic [ENERGY_W-1:0]  r_rem;
    logic [ALU_W-1:0]     r_div_r;
    logic [OUT_W-1:0]     r_num_lo;
    logic [OUT_W-1:0]     r_q;
    logic [2:0]           r_step;
    logic                 r_valid;
    logic [OUT_W-1:0]     r_out_row;
    logic [OUT_W-1:0]     r_out_col;
    logic [OUT_W-1:0]     r_out_conf;
    logic                 r_out_last;

    logic [CFG_W-1:0]     w_rows;
    logic [CFG_W-1:0]     w_cols;
    logic [CNT_W-1:0]     w_rows_m1;
    logic [CNT_W-1:0]     w_cols_m1;
    logic                 w_accept;
    logic                 w_load;
    logic                 w_fetch;
    logic [RW-1:0]        w_pos_row;
    logic [CW-1:0]        w_pos_col;
    logic                 w_pos_col_end;
    logic                 w_pos_row_end;
    logic [PIX_W-1:0]     w_base_min;
    logic                 w_re;
    logic [AW-1:0]        w_raddr;
    logic [PIX_W-1:0]     w_rdata;
    logic [PIX_W-1:0]     w_diff;
    logic [SQ_W-1:0]      w_diff_ext;
    logic                 w_emit_row_end;
    logic                 w_emit_col_end;
    logic                 w_walk_end;
    logic [CNT_W-1:0]     w_emit_row_ext;
    logic [CNT_W-1:0]     w_emit_col_ext;
    logic [NUM_W-1:0]     w_num;
    logic [ALU_W-1:0]     w_div_t;
    logic [OUT_W-1:0]     n_q;
    t_alu_req             w_alu_req;
    t_alu_rsp             w_alu_rsp;

    // Clamp the configured sizes into the supported range
    always_comb begin
        if (r_cfg_rows == '0) begin
            w_rows = CFG_W'(1);
        end else if (CNT_W'(r_cfg_rows) > CNT_W'(MAX_ROWS)) begin
            w_rows = CFG_W'(MAX_ROWS);
        end else begin
            w_rows = r_cfg_rows;
        end
        if (r_cfg_cols == '0) begin
            w_cols = CFG_W'(1);
        end else if (CNT_W'(r_cfg_cols) > CNT_W'(MAX_COLS)) begin
            w_cols = CFG_W'(MAX_COLS);
        end else begin
            w_cols = r_cfg_cols;
        end
    end

    assign w_rows_m1 = CNT_W'(w_rows) - CNT_W'(1);
    assign w_cols_m1 = CNT_W'(w_cols) - CNT_W'(1);

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_load   = w_accept && (i_kind == KIND_LOAD);
    assign w_fetch  = w_accept && (i_kind == KIND_FETCH) && r_ready;

    // Load position: a load after a complete image restarts at the origin
    assign w_pos_row     = r_full ? '0 : r_ld_row;
    assign w_pos_col     = r_full ? '0 : r_ld_col;
    assign w_pos_col_end = (CNT_W'(w_pos_col) == w_cols_m1);
    assign w_pos_row_end = (CNT_W'(w_pos_row) == w_rows_m1);
    assign w_base_min    = r_full ? 8'hFF : r_min;

    assign w_emit_row_ext = CNT_W'(r_emit_row);
    assign w_emit_col_ext = CNT_W'(r_emit_col);
    assign w_emit_row_end = (w_emit_row_ext == w_rows_m1);
    assign w_emit_col_end = (w_emit_col_ext == w_cols_m1);
    assign w_walk_end     = (CNT_W'(r_walk_row) == w_rows_m1);

    // Read port: the column walk, or the row above on a later fetch
    always_comb begin
        w_re    = 1'b0;
        w_raddr = {r_walk_row, r_emit_col};
        if (r_state == S_SUM) begin
            w_re = r_walk_busy;
        end else if (w_fetch && (r_emit_row != '0)) begin
            w_re    = 1'b1;
            w_raddr = {r_emit_row - RW'(1), r_emit_col};
        end
    end

    scm_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr ({w_pos_row, w_pos_col}),
        .i_wdata (i_pixel),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Offset from the image minimum, floored at zero
    assign w_diff     = (w_rdata >= r_min) ? (w_rdata - r_min) : '0;
    assign w_diff_ext = SQ_W'(w_diff);

    // Scaled numerator 255 * remaining and the next division trial value
    assign w_num   = {r_rem, {OUT_W{1'b0}}} - NUM_W'(r_rem);
    assign w_div_t = {r_div_r[ALU_W-2:0], r_num_lo[OUT_W-1]};

    // Route the shared unit by sequencer state
    always_comb begin
        w_alu_req.op = ALU_SUB;
        w_alu_req.a  = w_div_t;
        w_alu_req.b  = ALU_W'(r_total);
        case (r_state)
            S_SUM: begin
                w_alu_req.op = ALU_ADD;
                w_alu_req.a  = ALU_W'(r_total);
                w_alu_req.b  = ALU_W'(r_sq);
            end
            S_SUB: begin
                w_alu_req.a = ALU_W'(r_rem);
                w_alu_req.b = ALU_W'(r_sq);
            end
            default: begin
                w_alu_req.a = w_div_t;
            end
        endcase
    end

    scm_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign n_q = {r_q[OUT_W-2:0], !w_alu_rsp.borrow};

    // Sequencer, image tracking and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_rows  <= CFG_W'(256);
            r_cfg_cols  <= CFG_W'(256);
            r_min       <= 8'hFF;
            r_full      <= 1'b0;
            r_ready     <= 1'b0;
            r_ld_row    <= '0;
            r_ld_col    <= '0;
            r_emit_row  <= '0;
            r_emit_col  <= '0;
            r_walk_busy <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                // Any register write abandons the current image
                if (i_cfg_idx == REG_ROWS) begin
                    r_cfg_rows <= i_cfg_data;
                end else begin
                    r_cfg_cols <= i_cfg_data;
                end
                r_min      <= 8'hFF;
                r_full     <= 1'b0;
                r_ready    <= 1'b0;
                r_ld_row   <= '0;
                r_ld_col   <= '0;
                r_emit_row <= '0;
                r_emit_col <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_load) begin
                        // Store the pixel, track the minimum, advance position
                        r_min <= (i_pixel < w_base_min) ? i_pixel : w_base_min;
                        if (w_pos_col_end) begin
                            r_ld_col <= '0;
                            r_ld_row <= w_pos_row + RW'(1);
                        end else begin
                            r_ld_col <= w_pos_col + CW'(1);
                            r_ld_row <= w_pos_row;
                        end
                        r_full     <= w_pos_col_end && w_pos_row_end;
                        r_ready    <= w_pos_col_end && w_pos_row_end;
                        r_emit_row <= '0;
                        r_emit_col <= '0;
                    end else if (w_fetch) begin
                        if (r_emit_row == '0) begin
                            r_walk_row  <= '0;
                            r_walk_busy <= 1'b1;
                            r_v1        <= 1'b0;
                            r_v2        <= 1'b0;
                            r_total     <= '0;
                            r_state     <= S_SUM;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SUM: begin
                    // Walk the column: read, square, accumulate
                    if (r_walk_busy) begin
                        r_walk_row <= r_walk_row + RW'(1);
                        if (w_walk_end) begin
                            r_walk_busy <= 1'b0;
                        end
                    end
                    r_v1 <= r_walk_busy;
                    r_v2 <= r_v1;
                    if (r_v1) begin
                        r_sq <= w_diff_ext * w_diff_ext;
                    end
                    if (r_v2) begin
                        r_total <= w_alu_rsp.res[ENERGY_W-1:0];
                        r_rem   <= w_alu_rsp.res[ENERGY_W-1:0];
                    end
                    if (!r_walk_busy && !r_v1 && !r_v2) begin
                        r_rem      <= r_total;
                        r_out_conf <= CONF_FULL;
                        r_valid    <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_SQ: begin
                    r_sq    <= w_diff_ext * w_diff_ext;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    // Drop the energy of the row above, floored at zero
                    r_rem   <= w_alu_rsp.borrow ? '0 : w_alu_rsp.res[ENERGY_W-1:0];
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    if (r_total == '0) begin
                        r_out_conf <= CONF_FULL;
                        r_valid    <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_div_r  <= ALU_W'(w_num[NUM_W-1:OUT_W]);
                        r_num_lo <= w_num[OUT_W-1:0];
                        r_q      <= '0;
                        r_step   <= '0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle
                    r_div_r  <= w_alu_rsp.borrow ? w_div_t : w_alu_rsp.res;
                    r_num_lo <= {r_num_lo[OUT_W-2:0], 1'b0};
                    r_q      <= n_q;
                    r_step   <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_out_conf <= n_q;
                        r_valid    <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // Present the result and advance the fetch position
            if (((r_state == S_SUM) && !r_walk_busy && !r_v1 && !r_v2) ||
                ((r_state == S_NUM) && (r_total == '0)) ||
                ((r_state == S_DIV) && (r_step == 3'd7))) begin
                r_out_row  <= w_emit_row_ext[OUT_W-1:0];
                r_out_col  <= w_emit_col_ext[OUT_W-1:0];
                r_out_last <= w_emit_row_end && w_emit_col_end;
                if (w_emit_row_end && w_emit_col_end) begin
                    r_ready <= 1'b0;
                end else if (w_emit_row_end) begin
                    r_emit_row <= '0;
                    r_emit_col <= r_emit_col + CW'(1);
                end else begin
                    r_emit_row <= r_emit_row + RW'(1);
                end
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_confidence = r_out_conf;
    assign o_last       = r_out_last;

endmodule

/* bench/scm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_checker
// Watches the request, configuration and result ports of the scan-line
// confidence map, keeps its own copy of the loaded image and predicts each
// confidence value. Results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module scm_checker #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic                      i_kind,
    input  logic [scm_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [scm_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_valid,
    input  logic [scm_pkg::OUT_W-1:0] i_out_row,
    input  logic [scm_pkg::OUT_W-1:0] i_out_col,
    input  logic [scm_pkg::OUT_W-1:0] i_confidence,
    input  logic                      i_last,
    output int                        o_fail_count,
    output int                        o_pending
);
    import scm_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] conf;
        logic             last;
    } t_conf_value;

    // Image copy and scan state
    logic [PIX_W-1:0]  pix_mem [0:MAX_ROWS*MAX_COLS-1];
    logic [CFG_W-1:0]  cfg_rows;
    logic [CFG_W-1:0]  cfg_cols;
    int                lo_level;
    int                pix_count;
    int                next_row;
    int                next_col;
    longint unsigned   col_energy;
    longint unsigned   energy_left;
    bit                image_done;
    t_conf_value       conf_backlog[$];
    int                fail_total;

    // Clamp a size register to the range the block supports
    function automatic int span(logic [CFG_W-1:0] raw, int cap);
        if (raw == 0) return 1;
        return (raw > cap) ? cap : int'(raw);
    endfunction

    function automatic longint unsigned cell_energy(int r, int c);
        int p;
        int d;
        p = pix_mem[r*MAX_COLS + c];
        d = (p >= lo_level) ? p - lo_level : 0;
        return longint'(d) * longint'(d);
    endfunction

    function automatic void match_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endfunction

    task automatic restart_image();
        lo_level    = 255;
        pix_count   = 0;
        next_row    = 0;
        next_col    = 0;
        col_energy  = 0;
        energy_left = 0;
        image_done  = 0;
    endtask

    // Store one pixel at the next row-major position
    task automatic track_load(logic [PIX_W-1:0] px);
        int rows;
        int cols;
        int total;
        rows  = span(cfg_rows, MAX_ROWS);
        cols  = span(cfg_cols, MAX_COLS);
        total = rows * cols;
        if (pix_count >= total) restart_image();
        pix_mem[(pix_count / cols)*MAX_COLS + pix_count % cols] = px;
        if (px < lo_level) lo_level = px;
        pix_count++;
        if (pix_count == total) begin
            image_done = 1;
            next_row   = 0;
            next_col   = 0;
        end
    endtask

    // Work out the value a fetch yields, if any, and queue it
    task automatic predict_confidence();
        int              rows;
        int              cols;
        int              level;
        longint unsigned e;
        t_conf_value     v;
        rows = span(cfg_rows, MAX_ROWS);
        cols = span(cfg_cols, MAX_COLS);
        if (!image_done || next_row >= rows || next_col >= cols) return;
        if (next_row == 0) begin
            // Column start: sum the whole column
            col_energy = 0;
            for (int r = 0; r < rows; r++) col_energy += cell_energy(r, next_col);
            energy_left = col_energy;
            level = 255;
        end else begin
            e = cell_energy(next_row - 1, next_col);
            energy_left = (energy_left >= e) ? energy_left - e : 0;
            if (col_energy == 0) level = 255;
            else level = int'((255 * energy_left) / col_energy);
        end
        v.row  = OUT_W'(next_row);
        v.col  = OUT_W'(next_col);
        v.conf = OUT_W'(level);
        v.last = (next_row == rows - 1) && (next_col == cols - 1);
        conf_backlog.push_back(v);
        // Advance down the column, then to the next one
        if (v.last) begin
            image_done = 0;
        end else if (next_row + 1 >= rows) begin
            next_row = 0;
            next_col++;
        end else begin
            next_row++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_conf_value want;
        if (!i_rst_n) begin
            cfg_rows   = CFG_W'(MAX_ROWS);
            cfg_cols   = CFG_W'(MAX_COLS);
            fail_total = 0;
            conf_backlog.delete();
            restart_image();
        end else begin
            // Compare each result with the oldest prediction
            if (i_valid) begin
                if (conf_backlog.size() == 0) begin
                    $error("result with nothing expected: row %0d col %0d conf %0d",
                           i_out_row, i_out_col, i_confidence);
                    fail_total++;
                end else begin
                    want = conf_backlog.pop_front();
                    match_field("out_row", want.row, i_out_row);
                    match_field("out_col", want.col, i_out_col);
                    match_field("confidence", want.conf, i_confidence);
                    match_field("last", want.last, i_last);
                end
            end
            // Any register write drops the current image
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ROWS) cfg_rows = i_cfg_data;
                else cfg_cols = i_cfg_data;
                restart_image();
            end
            if (i_start && !i_busy) begin
                if (i_kind == KIND_LOAD) track_load(i_pixel);
                else predict_confidence();
            end
        end
        o_pending    <= conf_backlog.size();
        o_fail_count <= fail_total;
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives image loads, confidence fetches and size writes into the scan-line
// confidence map: a directed opening, the size extremes, then random images
// of many shapes and pixel patterns, with random request gaps.
// ----------------------------------------------------------------------------
module testbench;
    import scm_pkg::*;

    localparam int MAX_ROWS      = 256;
    localparam int MAX_COLS      = 256;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int WORK_ITEMS    = 1300;
    localparam int TAIL_ITEMS    = 1150;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 300;

    typedef enum int {
        PAT_NOISE,
        PAT_FLAT,
        PAT_NARROW,
        PAT_FLAT_COLS,
        PAT_RAILS
    } t_pattern;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             i_kind     = KIND_LOAD;
    logic [PIX_W-1:0] i_pixel    = '0;
    logic             i_cfg_we   = 1'b0;
    logic             i_cfg_idx  = REG_ROWS;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             busy;
    logic             o_valid;
    logic [OUT_W-1:0] o_out_row;
    logic [OUT_W-1:0] o_out_col;
    logic [OUT_W-1:0] o_confidence;
    logic             o_last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int work_items  = 0;
    int gap_pct     = 0;
    bit tail_part   = 0;

    always #2 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    scanline_confidence_map #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_confidence(o_confidence),
        .o_last      (o_last)
    );

    scm_checker #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_kind      (i_kind),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (o_valid),
        .i_out_row   (o_out_row),
        .i_out_col   (o_out_col),
        .i_confidence(o_confidence),
        .i_last      (o_last),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic int in_use(int raw, int cap);
        if (raw == 0) return 1;
        return (raw > cap) ? cap : raw;
    endfunction

    // Present one request, with an optional gap first, and hold it until taken
    task automatic issue(logic kind, logic [PIX_W-1:0] px, bit counts);
        if (!tail_part && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_kind  <= kind;
        i_pixel <= px;
        do @(posedge i_clk); while (busy);
        if (counts) work_items++;
        if (work_items >= TAIL_ITEMS) tail_part = 1;
    endtask

    task automatic load(logic [PIX_W-1:0] px);
        issue(KIND_LOAD, px, 1);
    endtask

    task automatic fetch(bit counts);
        issue(KIND_FETCH, PIX_W'($urandom_range(0, 255)), counts);
    endtask

    // Drop start and wait until every predicted value has come out
    task automatic settle();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Hold one register write for a cycle; the caller drops the enable
    task automatic write_register(logic idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic configure(int rows_raw, int cols_raw);
        settle();
        write_register(REG_ROWS, CFG_W'(rows_raw));
        write_register(REG_COLS, CFG_W'(cols_raw));
        i_cfg_we <= 1'b0;
    endtask

    // Load one full image with a random pattern, maybe with an early fetch
    task automatic send_image(int rows, int cols);
        t_pattern pat;
        int       total;
        int       early_at;
        int       lowv;
        int       salt;
        int       c;
        int       px;
        total    = rows * cols;
        early_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, total - 1) : -1;
        lowv     = $urandom_range(0, 100);
        salt     = $urandom_range(0, 2);
        case ($urandom_range(0, 9))
            0, 1, 2: pat = PAT_NOISE;
            3:       pat = PAT_FLAT;
            4, 5:    pat = PAT_NARROW;
            6, 7:    pat = PAT_FLAT_COLS;
            default: pat = PAT_RAILS;
        endcase
        for (int i = 0; i < total; i++) begin
            if (i == early_at) fetch(0);
            c = i % cols;
            case (pat)
                PAT_FLAT:      px = lowv;
                PAT_NARROW:    px = lowv + $urandom_range(0, 3);
                PAT_FLAT_COLS: px = ((c + salt) % 3 == 0) ? lowv
                                                          : $urandom_range(lowv, 255);
                PAT_RAILS:     px = $urandom_range(0, 1) ? 255 : 0;
                default:       px = $urandom_range(0, 255);
            endcase
            load(PIX_W'(px));
        end
    endtask

    // Fetch the whole image plus a few past its end, or stop part way
    task automatic read_image(int rows, int cols);
        int total;
        total = rows * cols;
        if ($urandom_range(0, 9) < 8) begin
            repeat (total) fetch(1);
            repeat ($urandom_range(0, 2)) fetch(0);
        end else begin
            repeat ($urandom_range(0, total - 1)) fetch(1);
        end
    endtask

    task automatic run_phase(int rows_raw, int cols_raw, int images);
        int rows;
        int cols;
        configure(rows_raw, cols_raw);
        case ($urandom_range(0, 3))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            2:       gap_pct = 30;
            default: gap_pct = 60;
        endcase
        rows = in_use(rows_raw, MAX_ROWS);
        cols = in_use(cols_raw, MAX_COLS);
        for (int i = 0; i < images; i++) begin
            send_image(rows, cols);
            read_image(rows, cols);
        end
        // Sometimes leave a half-loaded image for the next write to drop
        if (rows * cols > 1 && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, rows * cols - 1)) load(PIX_W'($urandom_range(0, 255)));
        end
    endtask

    function automatic int pick_size(bit may_be_long);
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 0;
        if (roll == 1 && may_be_long) return $urandom_range(13, 48);
        return $urandom_range(1, 12);
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: early fetches, flat column, past-end fetch, reload
        fetch(0);
        configure(3, 2);
        fetch(0);
        load(8'd0);
        load(8'd255);
        fetch(0);
        load(8'd0);
        load(8'd128);
        load(8'd0);
        load(8'd7);
        for (int i = 0; i < 7; i++) fetch(i < 6);
        load(8'd9);
        // Flat image, then a reload before all values were read
        configure(2, 1);
        load(8'd200);
        load(8'd200);
        fetch(1);
        fetch(1);
        load(8'd1);
        load(8'd4);
        fetch(1);
        load(8'd255);
        load(8'd0);
        fetch(1);
        fetch(1);

        // Size extremes, out-of-range values included
        run_phase(511, 0, 1);
        run_phase(0, 256, 1);

        // Random images of many shapes
        while (work_items < WORK_ITEMS) begin
            run_phase(pick_size(1), pick_size(0), $urandom_range(1, 3));
        end

        // Drain
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

/* scanline_confidence_map.f */
hw/rtl/scm_pkg.sv
hw/rtl/scm_alu.sv
hw/rtl/scm_store.sv
hw/rtl/scanline_confidence_map.sv
bench/scm_checker.sv
bench/testbench.sv
